// ===== rtl/bca_pkg.sv =====
// Package for the bitmap contiguous allocator: field widths, request codes and states.
// Used by the allocator top level and by its assertion checker.
package bca_pkg;

	localparam int POOL_ENTRIES_DEF = 256;
	localparam int WORD_W = 8;
	localparam int BIT_W = $clog2(WORD_W);
	localparam int REQ_W = 2;
	localparam int SIDX_W = 8;
	localparam int CNT_W = 9;
	localparam logic [CNT_W-1:0] ENTRIES_RESET = 9'd256;

	typedef enum logic [REQ_W-1:0] {
		REQ_FIND = 2'd0,
		REQ_TAKE = 2'd1,
		REQ_FREE = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/bitmap_contiguous_allocator.sv =====
// Bitmap first-fit run allocator with take, free and find requests.
// Depends on bca_pkg for widths, request codes and sequencer states.
// A request is taken only in the idle state and in_stall stays high until its result is loaded,
// so a new request is not accepted before the last one is through; a stalled result holds the
// next one in ST_FINISH. One row-scan unit visits one 8-entry bitmap row per cycle.
// Reset: asynchronous, active low; a clearing pass then writes ceil(POOL_ENTRIES/8)
// rows (32 at default) while in_stall stays high; configuration writes are taken throughout.
module bitmap_contiguous_allocator #(
	parameter int POOL_ENTRIES = bca_pkg::POOL_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bca_pkg::CNT_W-1:0]  cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [bca_pkg::REQ_W-1:0]  req_type,
	input  logic [bca_pkg::SIDX_W-1:0] start_index,
	input  logic [bca_pkg::CNT_W-1:0]  run_length,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [bca_pkg::SIDX_W-1:0] found_index,
	output logic [bca_pkg::CNT_W-1:0]  free_count,
	output logic                       need_compaction
);
	import bca_pkg::*;

	localparam int ROWS = (POOL_ENTRIES + WORD_W - 1) / WORD_W;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RC_W = ROW_W + 1;
	localparam int IDX_W = ROW_W + BIT_W;
	localparam int CMP_W = ((IDX_W > CNT_W + 1) ? IDX_W : CNT_W + 1) + 1;

	logic [WORD_W-1:0] map_mem [ROWS];

	state_t state_q, state_d;
	logic [RC_W-1:0] row_q, row_d;
	logic issue, wr_en, acc_in, out_load;
	logic [ROW_W-1:0] waddr;
	logic [WORD_W-1:0] wdata, row_new;
	logic rd_v_s1;
	logic [ROW_W-1:0] prow_s1;
	logic [WORD_W-1:0] rd_s1;

	logic [CNT_W-1:0] entries_q;
	req_t req_q;
	logic mod_q, set_q;
	logic [CMP_W-1:0] start_q, end_q;
	logic [CNT_W-1:0] len_q, n_q, n_cur;
	logic [RC_W-1:0] nrows_q;
	logic [CNT_W:0] nrows_sum;

	logic [CNT_W-1:0] run_q, run_d, hidx_q, hidx_d, free_q, free_d;
	logic hit_q, hit_d;

	logic fits;
	logic [CNT_W-1:0] where;

	logic out_valid_q, found_q, need_q;
	logic [SIDX_W-1:0] found_index_q;
	logic [CNT_W-1:0] free_count_q;

	assign acc_in = (state_q == ST_IDLE) && in_valid;
	assign n_cur = (CMP_W'(entries_q) < CMP_W'(POOL_ENTRIES)) ? entries_q
		: CNT_W'(POOL_ENTRIES);
	assign nrows_sum = {1'b0, n_cur} + (CNT_W + 1)'(WORD_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (cfg_wr_en) begin
			entries_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			row_q <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q <= row_d;
			rd_v_s1 <= issue;
		end
	end

	always_comb begin
		state_d = state_q;
		row_d = row_q;
		issue = 1'b0;
		wr_en = 1'b0;
		waddr = prow_s1;
		wdata = row_new;
		out_load = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				waddr = row_q[ROW_W-1:0];
				wdata = '0;
				row_d = row_q + 1'b1;
				if (row_q == RC_W'(ROWS - 1)) begin
					row_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				row_d = '0;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (row_q < nrows_q) begin
					issue = 1'b1;
					row_d = row_q + 1'b1;
				end
				if (rd_v_s1 && mod_q) begin
					wr_en = 1'b1;
				end
				if ((row_q == nrows_q) && !rd_v_s1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			prow_s1 <= row_q[ROW_W-1:0];
			rd_s1 <= map_mem[row_q[ROW_W-1:0]];
		end
		if (wr_en) begin
			map_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			req_q <= req_t'(req_type);
			mod_q <= (req_t'(req_type) == REQ_TAKE) || (req_t'(req_type) == REQ_FREE);
			set_q <= (req_t'(req_type) == REQ_TAKE);
			start_q <= CMP_W'(start_index);
			end_q <= CMP_W'(start_index) + CMP_W'(run_length);
			len_q <= run_length;
			n_q <= n_cur;
			nrows_q <= RC_W'(nrows_sum >> BIT_W);
		end
	end

	always_comb begin
		logic [CMP_W-1:0] idx;
		logic managed;
		logic in_span;
		logic [CNT_W-1:0] run;
		logic hit;
		logic [CNT_W-1:0] hidx;
		logic [CNT_W-1:0] fcnt;
		run = run_q;
		hit = hit_q;
		hidx = hidx_q;
		fcnt = free_q;
		row_new = rd_s1;
		for (int k = 0; k < WORD_W; k++) begin
			idx = CMP_W'({prow_s1, BIT_W'(k)});
			managed = idx < CMP_W'(n_q);
			in_span = (idx >= start_q) && (idx < end_q);
			if (managed && in_span && mod_q) begin
				row_new[k] = set_q;
			end
			if (managed && !row_new[k]) begin
				fcnt = fcnt + 1'b1;
			end
			if (managed && !hit) begin
				if (row_new[k]) begin
					run = '0;
				end else begin
					run = run + 1'b1;
					if (run == len_q) begin
						hit = 1'b1;
						hidx = idx[CNT_W-1:0];
					end
				end
			end
		end
		run_d = run;
		hit_d = hit;
		hidx_d = hidx;
		free_d = fcnt;
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			run_q <= '0;
			hit_q <= 1'b0;
			hidx_q <= '0;
			free_q <= '0;
		end else if (rd_v_s1) begin
			run_q <= run_d;
			hit_q <= hit_d;
			hidx_q <= hidx_d;
			free_q <= free_d;
		end
	end

	assign fits = hit_q || (len_q == '0);
	assign where = (len_q == '0) ? '0 : (hidx_q + 1'b1 - len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q <= (req_q == REQ_FIND) && fits;
			found_index_q <= ((req_q == REQ_FIND) && fits) ? where[SIDX_W-1:0] : '0;
			free_count_q <= free_q;
			need_q <= (free_q >= len_q) && !fits;
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign found_index = found_index_q;
	assign free_count = free_count_q;
	assign need_compaction = need_q;

endmodule

// ===== rtl/bca_checker.sv =====
// Port-level assertion checker for the bitmap contiguous allocator, bound to its top level.
// Depends on bca_pkg for the port widths.
module bca_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       found,
	input logic [bca_pkg::SIDX_W-1:0] found_index,
	input logic [bca_pkg::CNT_W-1:0]  free_count,
	input logic                       need_compaction
);
	import bca_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(found_index)
			&& $stable(free_count) && $stable(need_compaction))
		else $error("Stalled result word changed.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Input taken again right after an accepted word.");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> found_index == '0)
		else $error("Nonzero found_index without found.");

	a_found_no_compaction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> !need_compaction)
		else $error("Compaction flagged although a run was found.");

endmodule

bind bitmap_contiguous_allocator bca_checker u_bca_checker (.*);

// ===== tb/sv/tb_bitmap_contiguous_allocator.sv =====
// Self-checking testbench for bitmap_contiguous_allocator: directed and random find, take and
// free words under several managed-entry settings and idle patterns, checked against a tracker.
// Depends on bca_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module tb_bitmap_contiguous_allocator;
	import bca_pkg::*;

	typedef struct packed {
		logic                found;
		logic [SIDX_W-1:0]   found_index;
		logic [CNT_W-1:0]    free_count;
		logic                need_compaction;
	} alloc_result_t;

	typedef struct packed {
		logic [SIDX_W-1:0] start;
		logic [CNT_W-1:0]  len;
	} held_run_t;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	class alloc_tracker;
		bit [POOL_ENTRIES_DEF-1:0] occupied;
		logic [CNT_W-1:0] entries;
		alloc_result_t pending_results[$];
		int errors;
		int results_checked;
		int finds_hit;
		int compaction_seen;

		function new();
			occupied = '0;
			entries = ENTRIES_RESET;
			errors = 0;
			results_checked = 0;
			finds_hit = 0;
			compaction_seen = 0;
		endfunction

		function void set_entries(input logic [CNT_W-1:0] value);
			entries = value;
		endfunction

		function int managed();
			return (entries < POOL_ENTRIES_DEF) ? int'(entries) : POOL_ENTRIES_DEF;
		endfunction

		function bit first_fit(input int n, input int len, output int where);
			int i;
			int run;
			where = 0;
			run = 0;
			if (len == 0) begin
				return 1'b1;
			end
			for (i = 0; i < n; i++) begin
				if (occupied[i]) begin
					run = 0;
				end else begin
					run++;
					if (run == len) begin
						where = i + 1 - len;
						return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		function int free_entries();
			int i;
			int cnt;
			cnt = 0;
			for (i = 0; i < managed(); i++) begin
				if (!occupied[i]) cnt++;
			end
			return cnt;
		endfunction

		function void mark_run(input int n, input int start, input int len, input bit value);
			int i;
			int stop;
			stop = start + len;
			if (stop > n) stop = n;
			for (i = start; i < stop; i++) begin
				occupied[i] = value;
			end
		endfunction

		function void note_request(input logic [REQ_W-1:0] rq, input logic [SIDX_W-1:0] si,
				input logic [CNT_W-1:0] rl);
			int n;
			int where;
			int spare;
			int free_n;
			bit hit;
			bit fits;
			alloc_result_t r;
			n = managed();
			hit = 1'b0;
			where = 0;
			case (rq)
				REQ_FIND: hit = first_fit(n, int'(rl), where);
				REQ_TAKE: mark_run(n, int'(si), int'(rl), 1'b1);
				REQ_FREE: mark_run(n, int'(si), int'(rl), 1'b0);
				default: ;
			endcase
			free_n = free_entries();
			fits = first_fit(n, int'(rl), spare);
			r.found = hit;
			r.found_index = hit ? where[SIDX_W-1:0] : '0;
			r.free_count = free_n[CNT_W-1:0];
			r.need_compaction = (free_n >= int'(rl)) && !fits;
			pending_results.push_back(r);
		endfunction

		function void compare_field(input string name, input int want, input int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(input alloc_result_t got);
			alloc_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending, expected none, actual %h",
						$time, got);
				return;
			end
			want = pending_results.pop_front();
			results_checked++;
			if (got.found === 1'b1) finds_hit++;
			if (got.need_compaction === 1'b1) compaction_seen++;
			if (got !== want) begin
				compare_field("found", want.found, got.found);
				compare_field("found_index", want.found_index, got.found_index);
				compare_field("free_count", want.free_count, got.free_count);
				compare_field("need_compaction", want.need_compaction, got.need_compaction);
				if ($isunknown(got)) begin
					errors++;
					$display("%0t: unknown result bits, expected %h, actual %h",
							$time, want, got);
				end
			end
		endfunction

		function bit idle();
			return pending_results.size() == 0;
		endfunction
	endclass

	localparam int QUIET_LIMIT = 4000;
	localparam int ITEM_TARGET = 1000;
	localparam int PHASES = 8;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_stall;
	logic [REQ_W-1:0] req_type;
	logic [SIDX_W-1:0] start_index;
	logic [CNT_W-1:0] run_length;
	logic out_valid;
	logic out_stall;
	logic found;
	logic [SIDX_W-1:0] found_index;
	logic [CNT_W-1:0] free_count;
	logic need_compaction;

	alloc_tracker alloc_track;
	held_run_t held_runs[$];
	int in_idle_pct;
	int out_stall_pct;
	int words_sent;
	int directed_words;
	int quiet_cycles;

	bitmap_contiguous_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.start_index(start_index),
		.run_length(run_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.found_index(found_index),
		.free_count(free_count),
		.need_compaction(need_compaction)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			alloc_track.check_result({found, found_index, free_count, need_compaction});
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
				$display("bitmap_contiguous_allocator verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_word(input logic [REQ_W-1:0] rq, input logic [SIDX_W-1:0] si,
			input logic [CNT_W-1:0] rl);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < in_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		start_index <= si;
		run_length <= rl;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		alloc_track.note_request(rq, si, rl);
		words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (!alloc_track.idle()) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_entries(input logic [CNT_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		alloc_track.set_entries(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_word();
		int pick;
		int m;
		int len;
		int where;
		int k;
		held_run_t r;
		m = alloc_track.managed();
		pick = $urandom_range(99);
		if (alloc_track.free_entries() * 4 < m && held_runs.size() > 0 && pick < 70) begin
			pick = 55;
		end
		if (pick < 50) begin
			k = $urandom_range(99);
			if (k < 70) begin
				len = $urandom_range(1, 16);
			end else if (k < 90) begin
				len = $urandom_range(1, (m > 0) ? m : 1);
			end else if (k < 95) begin
				len = 0;
			end else begin
				len = $urandom_range(m, POOL_ENTRIES_DEF);
			end
			send_word(REQ_FIND, SIDX_W'($urandom_range(255)), CNT_W'(len));
			if (len > 0 && alloc_track.first_fit(m, len, where)) begin
				send_word(REQ_TAKE, SIDX_W'(where), CNT_W'(len));
				r.start = SIDX_W'(where);
				r.len = CNT_W'(len);
				held_runs.push_back(r);
			end
		end else if (pick < 65 && held_runs.size() > 0) begin
			k = $urandom_range(held_runs.size() - 1);
			r = held_runs[k];
			held_runs.delete(k);
			send_word(REQ_FREE, r.start, r.len);
		end else if (pick < 80) begin
			send_word(REQ_FREE, SIDX_W'($urandom_range(255)), CNT_W'($urandom_range(0, 24)));
		end else if (pick < 88) begin
			send_word(REQ_TAKE, SIDX_W'($urandom_range(255)), CNT_W'($urandom_range(0, 24)));
		end else begin
			send_word(REQ_W'($urandom_range(3)), SIDX_W'($urandom_range(255)),
					CNT_W'($urandom_range(POOL_ENTRIES_DEF)));
		end
	endtask

	initial begin
		logic [CNT_W-1:0] entry_settings [PHASES];
		int p;
		int target;
		entry_settings = '{9'd256, 9'd1, 9'd37, 9'd0, 9'd200, 9'd511, 9'd8, 9'd256};
		alloc_track = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		req_type = REQ_FIND;
		start_index = '0;
		run_length = '0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		words_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		write_entries(ENTRIES_RESET);

		send_word(REQ_FIND, 8'd0, 9'd0);
		send_word(REQ_FIND, 8'd255, 9'd256);
		send_word(REQ_TAKE, 8'd0, 9'd1);
		send_word(REQ_FIND, 8'd0, 9'd1);
		send_word(REQ_TAKE, 8'd250, 9'd20);
		send_word(REQ_FIND, 8'd0, 9'd256);
		send_word(REQ_TAKE, 8'd0, 9'd0);
		send_word(REQ_FREE, 8'd255, 9'd256);
		send_word(REQ_TAKE, 8'd10, 9'd5);
		send_word(REQ_FIND, 8'd0, 9'd240);
		send_word(REQ_FIND, 8'd0, 9'd245);
		send_word(REQ_UNUSED, 8'd255, 9'd256);
		send_word(REQ_TAKE, 8'd128, 9'd1);
		send_word(REQ_FIND, 8'd0, 9'd200);
		send_word(REQ_FREE, 8'd0, 9'd256);
		send_word(REQ_TAKE, 8'd255, 9'd1);
		send_word(REQ_FIND, 8'd0, 9'd256);
		send_word(REQ_FREE, 8'd255, 9'd1);
		drain_results();

		write_entries(9'd16);
		send_word(REQ_TAKE, 8'd8, 9'd100);
		send_word(REQ_FIND, 8'd0, 9'd17);
		send_word(REQ_FIND, 8'd0, 9'd8);
		send_word(REQ_TAKE, 8'd0, 9'd8);
		send_word(REQ_FIND, 8'd0, 9'd1);
		send_word(REQ_FREE, 8'd4, 9'd2);
		send_word(REQ_FIND, 8'd0, 9'd2);
		directed_words = words_sent;

		for (p = 0; p < PHASES; p++) begin
			drain_results();
			in_idle_pct = (p % 4 == 1) ? 74 : (p % 4 == 3) ? 20 : 0;
			out_stall_pct = (p % 4 == 2) ? 74 : (p % 4 == 3) ? 20 : 0;
			write_entries(entry_settings[p]);
			target = directed_words + (ITEM_TARGET * (p + 1)) / PHASES;
			while (words_sent < target) random_word();
		end

		drain_results();
		out_stall_pct = 0;
		repeat (40) @(posedge clk);
		$display("Sent %0d request words (%0d directed) across %0d entry settings.",
				words_sent, directed_words, PHASES + 2);
		$display("Checked %0d results: %0d successful finds, %0d compaction flags raised.",
				alloc_track.results_checked, alloc_track.finds_hit, alloc_track.compaction_seen);
		if (alloc_track.errors == 0 && alloc_track.idle()) begin
			$display("bitmap_contiguous_allocator verification clean");
		end else begin
			if (!alloc_track.idle()) begin
				$display("%0d results never arrived", alloc_track.pending_results.size());
			end
			$display("bitmap_contiguous_allocator verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bca_pkg.sv
rtl/bitmap_contiguous_allocator.sv
rtl/bca_checker.sv
tb/sv/tb_bitmap_contiguous_allocator.sv
